[rtl/core/dit_pkg.sv]
// Shared types and constants for the decimal integer tokenizer.
`default_nettype none

package dit_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_COMMENT_ENABLE = 1'b0;
    localparam logic CFG_MARKER_BYTE    = 1'b1;

    localparam logic [7:0] MARKER_RESET = 8'd42;

    // Character codes
    localparam logic [7:0] CH_ASTERISK = 8'h2A;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_NUMBER = 2'd0;
    localparam logic [1:0] ST_MARKER = 2'd1;
    localparam logic [1:0] ST_END    = 2'd2;

    localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic       comment_enable;
        logic [7:0] marker_byte;
    } cfg_t;

    typedef struct packed {
        logic               emit;
        logic signed [31:0] number;
        logic [1:0]         status;
        logic               saturated;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/dit_if.sv]
// Valid/ready channel interfaces for character beats and number beats.
`default_nettype none

interface dit_char_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_byte;

    modport source (output valid, output kind, output char_byte, input ready);
    modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

interface dit_num_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number;
    logic [1:0]         status;
    logic               saturated;

    modport source (output valid, output number, output status, output saturated, input ready);
    modport sink   (input valid, input number, input status, input saturated, output ready);
endinterface

`default_nettype wire

[rtl/core/decimal_integer_tokenizer.sv]
// A character beat is held in the input register, its number beat in the output register.
// One character beat per cycle unless numbers stall; the x10 accumulate is combinational.
// Input register and output register each hold one beat; with both full, a stalled number
// channel drops chars.ready in the same cycle.
// Reset (rst_n low, asynchronous): parser clears to skipping, both stages empty,
// comment_enable 0 and marker_byte 42.
`default_nettype none

module decimal_integer_tokenizer
    import dit_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    dit_char_if.sink        chars,
    dit_num_if.source       numbers
);

    cfg_t        cfg_reg;
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [7:0]  s1_char_reg;
    logic        out_valid_reg;
    res_t        out_reg;
    res_t        res;
    logic        out_free;
    logic        step_en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comment_enable <= 1'b0;
            cfg_reg.marker_byte    <= MARKER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COMMENT_ENABLE: cfg_reg.comment_enable <= cfg_data[0];
                CFG_MARKER_BYTE:    cfg_reg.marker_byte    <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Advance when the output slot is free or being emptied
    assign out_free     = !out_valid_reg || numbers.ready;
    assign step_en      = s1_valid_reg && out_free;
    assign chars.ready  = !s1_valid_reg || step_en;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (chars.ready)
            s1_valid_reg <= chars.valid;
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_kind_reg <= chars.kind;
            s1_char_reg <= chars.char_byte;
        end
    end

    dit_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .kind      (s1_kind_reg),
        .char_byte (s1_char_reg),
        .cfg       (cfg_reg),
        .res       (res)
    );

    // Output register: load a result beat, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en && res.emit)
            out_valid_reg <= 1'b1;
        else if (numbers.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res.emit)
            out_reg <= res;
    end

    assign numbers.valid     = out_valid_reg;
    assign numbers.number    = out_reg.number;
    assign numbers.status    = out_reg.status;
    assign numbers.saturated = out_reg.saturated;

endmodule

`default_nettype wire

[rtl/core/dit_parse.sv]
// Parse state and per-character step logic: sign, digit accumulate, saturate.
`default_nettype none

module dit_parse
    import dit_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic       kind,
    input  wire logic [7:0] char_byte,
    input  wire cfg_t       cfg,
    output res_t            res
);

    logic        in_digits_reg, in_digits_next;
    logic        negative_reg, negative_next;
    logic [30:0] magnitude_reg, magnitude_next;
    logic        overflowed_reg, overflowed_next;

    logic        is_end;
    logic        is_digit;
    logic        is_marker;
    logic [34:0] acc;
    logic [31:0] mag_ext;

    // Classify the byte
    assign is_end    = (kind == KIND_END);
    assign is_digit  = !is_end && (char_byte inside {[CH_ZERO:CH_NINE]});
    assign is_marker = cfg.comment_enable &&
                       ((char_byte == CH_ASTERISK) || (char_byte == CH_DOLLAR) ||
                        (char_byte == cfg.marker_byte));

    // Multiply by ten and add the digit
    assign acc = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
               + {31'd0, char_byte[3:0]};
    assign mag_ext = {1'b0, magnitude_reg};

    // Step the parser
    always_comb
    begin
        in_digits_next  = in_digits_reg;
        negative_next   = negative_reg;
        magnitude_next  = magnitude_reg;
        overflowed_next = overflowed_reg;
        res.emit        = 1'b0;
        res.number      = '1;
        res.status      = ST_NUMBER;
        res.saturated   = 1'b0;
        if (!in_digits_reg)
        begin
            if (is_end || is_marker)
            begin
                in_digits_next  = 1'b0;
                negative_next   = 1'b0;
                magnitude_next  = '0;
                overflowed_next = 1'b0;
                res.emit        = 1'b1;
                res.status      = is_end ? ST_END : ST_MARKER;
            end
            else if (is_digit)
            begin
                in_digits_next  = 1'b1;
                magnitude_next  = {27'd0, char_byte[3:0]};
                overflowed_next = 1'b0;
            end
            else
            begin
                negative_next = (char_byte == CH_MINUS);
            end
        end
        else if (is_digit)
        begin
            if (|acc[34:31])
            begin
                magnitude_next  = MAG_MAX;
                overflowed_next = 1'b1;
            end
            else
            begin
                magnitude_next = acc[30:0];
            end
        end
        else
        begin
            // Terminator consumed: emit the number and clear
            res.emit        = 1'b1;
            res.number      = negative_reg ? (32'd0 - mag_ext) : mag_ext;
            res.status      = ST_NUMBER;
            res.saturated   = overflowed_reg;
            in_digits_next  = 1'b0;
            negative_next   = 1'b0;
            magnitude_next  = '0;
            overflowed_next = 1'b0;
        end
    end

    // Hold state unless a beat is stepped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_digits_reg  <= 1'b0;
            negative_reg   <= 1'b0;
            magnitude_reg  <= '0;
            overflowed_reg <= 1'b0;
        end
        else if (step_en)
        begin
            in_digits_reg  <= in_digits_next;
            negative_reg   <= negative_next;
            magnitude_reg  <= magnitude_next;
            overflowed_reg <= overflowed_next;
        end
    end

endmodule

`default_nettype wire

[sim/decimal_integer_tokenizer_checker.sv]
// Checker for the decimal integer tokenizer: predicts number beats and compares them.
`timescale 1ns / 100ps

module decimal_integer_tokenizer_checker
    import dit_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_index,
    input  wire logic [7:0] cfg_data,
    dit_char_if       chars,
    dit_num_if        numbers,
    output int        errors,
    output int        outstanding,
    output int        char_beats,
    output int        number_beats,
    output int        saturated_beats,
    output int        marker_beats,
    output int        end_beats
);

    typedef struct packed {
        logic signed [31:0] number;
        logic [1:0]         status;
        logic               saturated;
    } num_beat_t;

    // Shadow copy of the configuration registers
    logic       comment_en;
    logic [7:0] marker;

    // Parser state as the block should hold it
    logic        in_digits;
    logic        negative;
    logic [30:0] magnitude;
    logic        overflowed;

    num_beat_t pending_numbers[$];

    function void clear_number();
        in_digits  = 1'b0;
        negative   = 1'b0;
        magnitude  = '0;
        overflowed = 1'b0;
    endfunction

    // Advance the parser by one character beat; return 1 when a number beat is due
    function bit parse_char(input logic kind, input logic [7:0] ch, output num_beat_t res);
        logic        is_digit;
        logic [34:0] acc;
        logic [31:0] value;
        is_digit = (kind == KIND_CHAR) && (ch >= CH_ZERO) && (ch <= CH_NINE);
        res = '0;
        if (!in_digits)
        begin
            if (kind == KIND_END)
            begin
                clear_number();
                res.number = -32'sd1;
                res.status = ST_END;
                return 1'b1;
            end
            // Marker check comes before the digit check, so a digit marker wins
            if (comment_en && (ch == CH_ASTERISK || ch == CH_DOLLAR || ch == marker))
            begin
                clear_number();
                res.number = -32'sd1;
                res.status = ST_MARKER;
                return 1'b1;
            end
            if (is_digit)
            begin
                in_digits  = 1'b1;
                magnitude  = 31'(ch - CH_ZERO);
                overflowed = 1'b0;
            end
            else
                negative = (ch == CH_MINUS);
            return 1'b0;
        end
        // Accumulate, clamping at the largest positive magnitude
        if (is_digit)
        begin
            acc = {4'b0, magnitude} * 35'd10 + 35'(ch - CH_ZERO);
            if (acc > 35'(MAG_MAX))
            begin
                magnitude  = MAG_MAX;
                overflowed = 1'b1;
            end
            else
                magnitude = acc[30:0];
            return 1'b0;
        end
        // Any non-digit or end of input closes the number and is consumed
        value = negative ? (32'd0 - {1'b0, magnitude}) : {1'b0, magnitude};
        res.number    = value;
        res.status    = ST_NUMBER;
        res.saturated = overflowed;
        clear_number();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        num_beat_t want;
        num_beat_t got;
        if (!rst_n)
        begin
            comment_en = 1'b0;
            marker     = MARKER_RESET;
            clear_number();
            pending_numbers.delete();
            errors          = 0;
            outstanding     = 0;
            char_beats      = 0;
            number_beats    = 0;
            saturated_beats = 0;
            marker_beats    = 0;
            end_beats       = 0;
        end
        else
        begin
            // Compare the number beat first, so it only meets older expectations
            if (numbers.valid && numbers.ready)
            begin
                got.number    = numbers.number;
                got.status    = numbers.status;
                got.saturated = numbers.saturated;
                number_beats++;
                if (got.saturated)
                    saturated_beats++;
                if (got.status == ST_MARKER)
                    marker_beats++;
                if (got.status == ST_END)
                    end_beats++;
                if (pending_numbers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected number beat: number %0d status %0d saturated %0d",
                             $time, got.number, got.status, got.saturated);
                end
                else
                begin
                    want = pending_numbers.pop_front();
                    if (got.number !== want.number)
                    begin
                        errors++;
                        $display("%0t: number mismatch: expected %0d, got %0d",
                                 $time, want.number, got.number);
                    end
                    if (got.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.saturated !== want.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated mismatch: expected %0d, got %0d",
                                 $time, want.saturated, got.saturated);
                    end
                end
            end

            // Track register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_COMMENT_ENABLE)
                    comment_en = cfg_data[0];
                else if (cfg_index == CFG_MARKER_BYTE)
                    marker = cfg_data;
            end

            // Predict from each accepted character beat
            if (chars.valid && chars.ready)
            begin
                char_beats++;
                if (parse_char(chars.kind, chars.char_byte, want))
                    pending_numbers.insert(pending_numbers.size(), want);
            end
            outstanding = pending_numbers.size();
        end
    end

endmodule

[sim/decimal_integer_tokenizer_tb.sv]
// Testbench top for the decimal integer tokenizer: stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module decimal_integer_tokenizer_tb;
    import dit_pkg::*;

    localparam int PHASES     = 5;
    localparam int PHASE_BEATS = 110;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    int src_idle_pct;
    int sink_stall_pct;
    int beats_sent;

    int errors;
    int outstanding;
    int char_beats;
    int number_beats;
    int saturated_beats;
    int marker_beats;
    int end_beats;

    dit_char_if chars_ch ();
    dit_num_if  nums_ch ();

    decimal_integer_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (chars_ch),
        .numbers   (nums_ch)
    );

    decimal_integer_tokenizer_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .chars           (chars_ch),
        .numbers         (nums_ch),
        .errors          (errors),
        .outstanding     (outstanding),
        .char_beats      (char_beats),
        .number_beats    (number_beats),
        .saturated_beats (saturated_beats),
        .marker_beats    (marker_beats),
        .end_beats       (end_beats)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Stall the number channel at random
    always @(negedge clk)
        nums_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    // Drive one character beat and hold it until accepted
    task automatic send_beat(input logic kind, input logic [7:0] ch);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            chars_ch.valid <= 1'b0;
            @(negedge clk);
        end
        chars_ch.valid     <= 1'b1;
        chars_ch.kind      <= kind;
        chars_ch.char_byte <= ch;
        do
            @(posedge clk);
        while (!chars_ch.ready);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_beat(KIND_CHAR, s[i]);
    endtask

    function automatic logic [7:0] non_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b >= CH_ZERO && b <= CH_NINE);
        return b;
    endfunction

    // Drop valid, wait for every number beat, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        chars_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_config(input logic en, input logic [7:0] mark);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COMMENT_ENABLE;
        cfg_data  <= {7'b0, en};
        @(negedge clk);
        cfg_index <= CFG_MARKER_BYTE;
        cfg_data  <= mark;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // One well-formed number: optional minus or other non-digit byte, digits, terminator
    task automatic send_token();
        int    roll;
        int    n;
        string lim;
        roll = $urandom_range(99);
        if (roll < 50)
            send_beat(KIND_CHAR, CH_MINUS);
        else if (roll < 80)
            send_beat(KIND_CHAR, non_digit());
        roll = $urandom_range(99);
        if (roll < 6)
        begin
            // Either side of the clamp point
            lim = $urandom_range(1) ? "2147483648" : "2147483647";
            send_text(lim);
        end
        else
        begin
            n = (roll < 70) ? $urandom_range(4, 1) :
                (roll < 90) ? $urandom_range(10, 5) : $urandom_range(13, 11);
            repeat (n) send_beat(KIND_CHAR, 8'(CH_ZERO + $urandom_range(9)));
        end
        if ($urandom_range(99) < 20)
            send_beat(KIND_END, 8'($urandom_range(255)));
        else
            send_beat(KIND_CHAR, non_digit());
    endtask

    // Stray beats: ends, marker candidates and arbitrary bytes
    task automatic send_noise(input logic [7:0] mark);
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            send_beat(KIND_END, 8'($urandom_range(255)));
        else if (roll < 40)
            send_beat(KIND_CHAR, CH_ASTERISK);
        else if (roll < 50)
            send_beat(KIND_CHAR, CH_DOLLAR);
        else if (roll < 60)
            send_beat(KIND_CHAR, mark);
        else
            send_beat(KIND_CHAR, 8'($urandom_range(255)));
    endtask

    // Run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int         phase;
        int         phase_start;
        int         src_pct[PHASES];
        int         sink_pct[PHASES];
        logic       en_tab[PHASES];
        logic [7:0] mark_tab[PHASES];

        src_pct  = '{0, 74, 0, 33, 0};
        sink_pct = '{0, 0, 74, 33, 0};
        en_tab   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        mark_tab = '{8'h00, 8'hFF, 8'hFF, 8'(CH_ZERO + $urandom_range(9)), CH_MINUS};

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_COMMENT_ENABLE;
        cfg_data           = '0;
        chars_ch.valid     = 1'b0;
        chars_ch.kind      = KIND_CHAR;
        chars_ch.char_byte = '0;
        nums_ch.ready      = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        beats_sent         = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset configuration, comments disabled
        send_text("-123 ");
        send_beat(KIND_CHAR, CH_ASTERISK);
        send_beat(KIND_END, 8'h00);
        // Clamp on a negative number, closed by end of input
        send_text("-9999999999");
        send_beat(KIND_END, 8'hFF);
        send_beat(KIND_CHAR, 8'h00);
        send_beat(KIND_CHAR, 8'hFF);
        send_text("0");
        send_beat(KIND_CHAR, 8'hFF);
        drain();

        // Directed: comments enabled with a digit as marker
        set_config(1'b1, CH_ZERO + 8'd7);
        send_beat(KIND_CHAR, CH_ZERO + 8'd7);
        send_beat(KIND_CHAR, CH_DOLLAR);
        send_text("1*");
        drain();

        // Random phases, each with its own configuration and idling
        for (phase = 0; phase < PHASES; phase++)
        begin
            src_idle_pct   = src_pct[phase];
            sink_stall_pct = sink_pct[phase];
            set_config(en_tab[phase], mark_tab[phase]);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
            begin
                if ($urandom_range(99) < 85)
                    send_token();
                else
                    send_noise(mark_tab[phase]);
            end
            drain();
        end

        $display("Run covered %0d character beats and %0d number beats over %0d phases.",
                 char_beats, number_beats, PHASES + 2);
        $display("Of those: %0d saturated, %0d comment markers, %0d ends without number.",
                 saturated_beats, marker_beats, end_beats);
        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
